// ===== sv/doubly_linked_box_reorder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Box reorder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_BOX_REORDER_CORE_MACROS_SVH
`define DOUBLY_LINKED_BOX_REORDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLBR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dlbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Box reorder package
// Field widths, action and status codes, and transaction payload types.
// ----------------------------------------------------------------------------
package dlbr_pkg;

    localparam int ACTION_W          = 3;
    localparam int BOX_W             = 11;
    localparam int SUM_W             = 20;
    localparam int CFG_W             = 11;
    localparam int MAX_BOXES_DEFAULT = 1024;

    localparam logic [CFG_W-1:0] BOX_COUNT_RESET = CFG_W'(1024);

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REBUILD = 3'd0,
        ACT_LEFT    = 3'd1,
        ACT_RIGHT   = 3'd2,
        ACT_SWAP    = 3'd3,
        ACT_REVERSE = 3'd4,
        ACT_QUERY   = 3'd5
    } t_action;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BOX_W-1:0]    first_box;
        logic [BOX_W-1:0]    second_box;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0] odd_position_sum;
        logic             status;
    } t_out_item;

endpackage

// ===== sv/dlbr_link_ram.sv =====
// ----------------------------------------------------------------------------
// Box reorder link memory
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dlbr_link_ram #(
    parameter int DEPTH = 1026,
    parameter int AW    = 11,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write and read; a read returns the contents before a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dlbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Box reorder sequencer
// Runs each memory action as a sequence of link memory reads and writes: rebuild
// sweep, read-modify-write for moves and swaps, and the query walk.
// ----------------------------------------------------------------------------
module dlbr_ctrl #(
    parameter int MAX_BOXES = dlbr_pkg::MAX_BOXES_DEFAULT,
    parameter int DEPTH     = MAX_BOXES + 2,
    parameter int IW        = $clog2(MAX_BOXES + 2)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dlbr_pkg::t_in_item          i_in,
    input  logic [dlbr_pkg::CFG_W-1:0]  i_box_count,
    input  logic                        i_res_free,
    output logic                        o_res_load,
    output dlbr_pkg::t_out_item         o_res,
    output logic                        o_prev_we,
    output logic [IW-1:0]               o_prev_waddr,
    output logic [IW-1:0]               o_prev_wdata,
    output logic [IW-1:0]               o_prev_raddr,
    input  logic [IW-1:0]               i_prev_rdata,
    output logic                        o_next_we,
    output logic [IW-1:0]               o_next_waddr,
    output logic [IW-1:0]               o_next_wdata,
    output logic [IW-1:0]               o_next_raddr,
    input  logic [IW-1:0]               i_next_rdata
);

    import dlbr_pkg::*;

    `include "doubly_linked_box_reorder_core_macros.svh"

    localparam int CW = (IW > BOX_W) ? IW : BOX_W;
    localparam logic [1:0] WSTEP_LAST = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD,
        ST_RDX,
        ST_RDY,
        ST_EVAL,
        ST_WRITE,
        ST_QSTART,
        ST_QWALK,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        K_LEFT,
        K_RIGHT,
        K_SWAP_NEXT,
        K_SWAP_PREV,
        K_SWAP_GEN
    } t_kind;

    t_state            r_state, n_state;
    t_kind             r_kind, n_kind;
    logic              r_built, n_built;
    logic              r_reversed, n_reversed;
    logic [IW-1:0]     r_active, n_active;
    logic              r_left, n_left;
    logic              r_swap, n_swap;
    logic [IW-1:0]     r_x, n_x;
    logic [IW-1:0]     r_y, n_y;
    logic [IW-1:0]     r_px, n_px;
    logic [IW-1:0]     r_nx, n_nx;
    logic [IW-1:0]     r_py, n_py;
    logic [IW-1:0]     r_ny, n_ny;
    logic [IW-1:0]     r_n, n_n;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_steps, n_steps;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [1:0]        r_wstep, n_wstep;
    t_out_item         r_res, n_res;

    t_action           act;
    logic [CW-1:0]     x_cw, y_cw, active_cw, cnt_cw, sat_cw;
    logic              bad_box;
    logic [IW-1:0]     cur, stop, n_end, active_end, p2, q2;
    logic              pl_pe, pl_ne;
    logic [IW-1:0]     pl_pa, pl_pd, pl_na, pl_nd;

    // Operand checks and rebuild count saturation.
    always_comb begin
        act       = t_action'(i_in.action);
        x_cw      = CW'(i_in.first_box);
        y_cw      = CW'(i_in.second_box);
        active_cw = CW'(r_active);
        bad_box   = (x_cw == '0) || (y_cw == '0) || (x_cw > active_cw) ||
                    (y_cw > active_cw) || (x_cw == y_cw);
        cnt_cw    = CW'(i_box_count);
        if (cnt_cw == '0) begin
            sat_cw = CW'(1);
        end else if (cnt_cw > CW'(MAX_BOXES)) begin
            sat_cw = CW'(MAX_BOXES);
        end else begin
            sat_cw = cnt_cw;
        end
    end

    // Link write plan for moves and swaps, one write per memory and step.
    // Writes to each memory keep program order, so aliased entries end
    // with the last value written.
    always_comb begin
        p2    = (r_y == r_nx) ? r_px : r_py;
        q2    = (r_y == r_px) ? r_nx : r_ny;
        pl_pe = 1'b1;
        pl_ne = 1'b1;
        pl_pa = '0;
        pl_pd = '0;
        pl_na = '0;
        pl_nd = '0;
        case (r_kind)
            K_LEFT: begin
                case (r_wstep)
                    2'd0: begin
                        pl_na = r_px; pl_nd = r_nx; pl_pa = r_nx; pl_pd = r_px;
                    end
                    2'd1: begin
                        pl_na = p2; pl_nd = r_x; pl_pa = r_x; pl_pd = p2;
                    end
                    2'd2: begin
                        pl_na = r_x; pl_nd = r_y; pl_pa = r_y; pl_pd = r_x;
                    end
                    default: begin
                        pl_pe = 1'b0; pl_ne = 1'b0;
                    end
                endcase
            end
            K_RIGHT: begin
                case (r_wstep)
                    2'd0: begin
                        pl_na = r_px; pl_nd = r_nx; pl_pa = r_nx; pl_pd = r_px;
                    end
                    2'd1: begin
                        pl_na = r_x; pl_nd = q2; pl_pa = q2; pl_pd = r_x;
                    end
                    2'd2: begin
                        pl_na = r_y; pl_nd = r_x; pl_pa = r_x; pl_pd = r_y;
                    end
                    default: begin
                        pl_pe = 1'b0; pl_ne = 1'b0;
                    end
                endcase
            end
            K_SWAP_NEXT: begin
                case (r_wstep)
                    2'd0: begin
                        pl_na = r_px; pl_nd = r_y; pl_pa = r_y; pl_pd = r_px;
                    end
                    2'd1: begin
                        pl_na = r_x; pl_nd = r_ny; pl_pa = r_ny; pl_pd = r_x;
                    end
                    2'd2: begin
                        pl_na = r_y; pl_nd = r_x; pl_pa = r_x; pl_pd = r_y;
                    end
                    default: begin
                        pl_pe = 1'b0; pl_ne = 1'b0;
                    end
                endcase
            end
            K_SWAP_PREV: begin
                case (r_wstep)
                    2'd0: begin
                        pl_na = r_y; pl_nd = r_nx; pl_pa = r_nx; pl_pd = r_y;
                    end
                    2'd1: begin
                        pl_na = r_py; pl_nd = r_x; pl_pa = r_x; pl_pd = r_py;
                    end
                    2'd2: begin
                        pl_na = r_x; pl_nd = r_y; pl_pa = r_y; pl_pd = r_x;
                    end
                    default: begin
                        pl_pe = 1'b0; pl_ne = 1'b0;
                    end
                endcase
            end
            default: begin
                // Neither neighbor case: both boxes trade all four links.
                case (r_wstep)
                    2'd0: begin
                        pl_na = r_px; pl_nd = r_y; pl_pa = r_nx; pl_pd = r_y;
                    end
                    2'd1: begin
                        pl_na = r_y; pl_nd = r_nx; pl_pa = r_y; pl_pd = r_px;
                    end
                    2'd2: begin
                        pl_na = r_py; pl_nd = r_x; pl_pa = r_ny; pl_pd = r_x;
                    end
                    default: begin
                        pl_na = r_x; pl_nd = r_ny; pl_pa = r_x; pl_pd = r_py;
                    end
                endcase
            end
        endcase
    end

    // Sequencer next state, memory ports and result.
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_built      = r_built;
        n_reversed   = r_reversed;
        n_active     = r_active;
        n_left       = r_left;
        n_swap       = r_swap;
        n_x          = r_x;
        n_y          = r_y;
        n_px         = r_px;
        n_nx         = r_nx;
        n_py         = r_py;
        n_ny         = r_ny;
        n_n          = r_n;
        n_idx        = r_idx;
        n_steps      = r_steps;
        n_sum        = r_sum;
        n_wstep      = r_wstep;
        n_res        = r_res;
        o_res_load   = 1'b0;
        o_prev_we    = 1'b0;
        o_prev_waddr = '0;
        o_prev_wdata = '0;
        o_prev_raddr = '0;
        o_next_we    = 1'b0;
        o_next_waddr = '0;
        o_next_wdata = '0;
        o_next_raddr = '0;
        n_end        = r_n + IW'(1);
        active_end   = r_active + IW'(1);
        cur          = r_reversed ? i_prev_rdata : i_next_rdata;
        stop         = r_reversed ? '0 : active_end;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_x                       = IW'(i_in.first_box);
                    n_y                       = IW'(i_in.second_box);
                    n_res.odd_position_sum    = '0;
                    n_res.status              = STATUS_DONE;
                    n_state                   = ST_DONE;
                    if (act == ACT_REBUILD) begin
                        n_n     = IW'(sat_cw);
                        n_idx   = '0;
                        n_state = ST_BUILD;
                    end else if (i_in.action > ACT_QUERY || !r_built) begin
                        n_res.status = STATUS_REJECT;
                    end else if (act == ACT_REVERSE) begin
                        n_reversed = !r_reversed;
                    end else if (act == ACT_QUERY) begin
                        n_state = ST_QSTART;
                    end else if (bad_box) begin
                        n_res.status = STATUS_REJECT;
                    end else begin
                        n_swap  = (act == ACT_SWAP);
                        n_left  = (act == ACT_LEFT) != r_reversed;
                        n_state = ST_RDX;
                    end
                end
            end
            ST_BUILD: begin
                // Identity order, one entry of both memories per cycle.
                o_prev_we    = 1'b1;
                o_prev_waddr = r_idx;
                o_prev_wdata = (r_idx == '0) ? '0 : r_idx - IW'(1);
                o_next_we    = 1'b1;
                o_next_waddr = r_idx;
                o_next_wdata = (r_idx == n_end) ? r_idx : r_idx + IW'(1);
                n_idx        = r_idx + IW'(1);
                if (r_idx == n_end) begin
                    n_built    = 1'b1;
                    n_reversed = 1'b0;
                    n_active   = r_n;
                    n_state    = ST_DONE;
                end
            end
            ST_RDX: begin
                o_prev_raddr = r_x;
                o_next_raddr = r_x;
                n_state      = ST_RDY;
            end
            ST_RDY: begin
                o_prev_raddr = r_y;
                o_next_raddr = r_y;
                n_px         = i_prev_rdata;
                n_nx         = i_next_rdata;
                n_state      = ST_EVAL;
            end
            ST_EVAL: begin
                // Classify the change; a move already in place is done.
                n_py    = i_prev_rdata;
                n_ny    = i_next_rdata;
                n_wstep = '0;
                n_state = ST_WRITE;
                if (r_swap) begin
                    if (r_nx == r_y) begin
                        n_kind = K_SWAP_NEXT;
                    end else if (r_px == r_y) begin
                        n_kind = K_SWAP_PREV;
                    end else begin
                        n_kind = K_SWAP_GEN;
                    end
                end else if (r_left) begin
                    n_kind = K_LEFT;
                    if (i_prev_rdata == r_x) begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_kind = K_RIGHT;
                    if (i_next_rdata == r_x) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WRITE: begin
                o_prev_we    = pl_pe;
                o_prev_waddr = pl_pa;
                o_prev_wdata = pl_pd;
                o_next_we    = pl_ne;
                o_next_waddr = pl_na;
                o_next_wdata = pl_nd;
                n_wstep      = r_wstep + 2'd1;
                if (r_wstep == WSTEP_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_QSTART: begin
                o_prev_raddr = active_end;
                o_next_raddr = '0;
                n_steps      = '0;
                n_sum        = '0;
                n_state      = ST_QWALK;
            end
            ST_QWALK: begin
                // One box per cycle: the read data is the next read address.
                o_prev_raddr = cur;
                o_next_raddr = cur;
                if (cur == stop || r_steps == r_active) begin
                    n_res.odd_position_sum = r_sum;
                    n_state                = ST_DONE;
                end else begin
                    if (!r_steps[0]) begin
                        n_sum = r_sum + SUM_W'(cur);
                    end
                    n_steps = r_steps + IW'(1);
                end
            end
            ST_DONE: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, control and working registers.
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_left  <= n_left;
        r_swap  <= n_swap;
        r_x     <= n_x;
        r_y     <= n_y;
        r_px    <= n_px;
        r_nx    <= n_nx;
        r_py    <= n_py;
        r_ny    <= n_ny;
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_steps <= n_steps;
        r_sum   <= n_sum;
        r_wstep <= n_wstep;
        r_res   <= n_res;
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_built    <= 1'b0;
            r_reversed <= 1'b0;
            r_active   <= '0;
        end else begin
            r_state    <= n_state;
            r_built    <= n_built;
            r_reversed <= n_reversed;
            r_active   <= n_active;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_res      = r_res;

    // Checks on sequencing.
    `DLBR_ASSERT_IMPLY(a_no_write_while_reading, (r_state == ST_RDX || r_state == ST_RDY || r_state == ST_EVAL || r_state == ST_QWALK), (!o_prev_we && !o_next_we), "link write during a read phase")
    `DLBR_ASSERT_IMPLY(a_walk_bounded, (r_state == ST_QWALK), (r_steps <= r_active), "query walk ran past the box count")
    `DLBR_ASSERT_IMPLY(a_write_in_range, (o_prev_we || o_next_we), (o_prev_waddr <= IW'(DEPTH - 1) && o_next_waddr <= IW'(DEPTH - 1)), "link write outside the memory")
    `DLBR_ASSERT_NEXT(a_built_sticky, r_built, r_built, "built flag cleared without reset")

endmodule

// ===== sv/doubly_linked_box_reorder_core.sv =====
// Sequence, from input transaction to output register: reverse and rejected actions go
// straight to the result state, a move or swap reads both boxes' links, classifies the
// change and writes (a move already in place skips the writes), rebuild sweeps, query walks.
// Flow control: one action at a time; the next input is taken in the cycle after the result
// is loaded, and a stalled full output register holds the sequencer in its last state.
// Reset: synchronous, active low; flags and active count clear, box count loads 1024.
// ----------------------------------------------------------------------------
// Box reorder core
// Boxes kept in a line as a doubly linked list in two link memories, with
// rebuild, move, swap, reverse and odd-position query actions.
// ----------------------------------------------------------------------------
module doubly_linked_box_reorder_core #(
    parameter int MAX_BOXES = dlbr_pkg::MAX_BOXES_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dlbr_pkg::t_in_item          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output dlbr_pkg::t_out_item         o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dlbr_pkg::CFG_W-1:0]  i_cfg_data
);

    import dlbr_pkg::*;

    localparam int DEPTH = MAX_BOXES + 2;
    localparam int IW    = $clog2(MAX_BOXES + 2);

    logic [CFG_W-1:0] r_box_count;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             res_free, res_load;
    t_out_item        res;
    logic             prev_we, next_we;
    logic [IW-1:0]    prev_waddr, prev_wdata, prev_raddr, prev_rdata;
    logic [IW-1:0]    next_waddr, next_wdata, next_raddr, next_rdata;

    // Box count register, written by a configuration transaction.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count <= BOX_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_box_count <= i_cfg_data;
        end
    end

    // Output register; it takes a new result when empty or being drained.
    assign res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer.
    dlbr_ctrl #(
        .MAX_BOXES (MAX_BOXES),
        .DEPTH     (DEPTH),
        .IW        (IW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_box_count  (r_box_count),
        .i_res_free   (res_free),
        .o_res_load   (res_load),
        .o_res        (res),
        .o_prev_we    (prev_we),
        .o_prev_waddr (prev_waddr),
        .o_prev_wdata (prev_wdata),
        .o_prev_raddr (prev_raddr),
        .i_prev_rdata (prev_rdata),
        .o_next_we    (next_we),
        .o_next_waddr (next_waddr),
        .o_next_wdata (next_wdata),
        .o_next_raddr (next_raddr),
        .i_next_rdata (next_rdata)
    );

    // Backward links.
    dlbr_link_ram #(
        .DEPTH (DEPTH),
        .AW    (IW),
        .DW    (IW)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    // Forward links.
    dlbr_link_ram #(
        .DEPTH (DEPTH),
        .AW    (IW),
        .DW    (IW)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (next_raddr),
        .o_rdata (next_rdata)
    );

endmodule
